// ===== design/etf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// etf_pkg
// shared constants, register indexes and control types of the escape-time
// fractal iterator
// ----------------------------------------------------------------------------
package etf_pkg;

    localparam int IN_WIDTH            = 32;
    localparam int IN_FRAC             = 28;
    localparam int INT_BITS            = 10;
    localparam int OUT_WIDTH           = 16;
    localparam int MAX_ITER_WIDTH      = 16;
    localparam int CFG_INDEX_WIDTH     = 8;
    localparam int CFG_DATA_WIDTH      = 32;

    localparam int FRAC_BITS_DEFAULT   = 28;
    localparam int COUNT_WIDTH_DEFAULT = 16;

    localparam logic [MAX_ITER_WIDTH-1:0] MAX_ITER_RESET = 16'd256;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FRACTAL_MODE   = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_JULIA_C_RE     = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_JULIA_C_IM     = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_ITERATIONS = 8'd3;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } etf_cmd_t;

    typedef struct packed {
        logic escaped;
        logic at_limit;
        logic out_free;
    } etf_status_t;

endpackage

`default_nettype wire

// ===== design/etf_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// etf_regs
// configuration register file: mode, julia constant and iteration limit
// ----------------------------------------------------------------------------
module etf_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [etf_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [etf_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    output logic                                      fractal_mode,
    output logic signed [etf_pkg::IN_WIDTH-1:0]       julia_c_re,
    output logic signed [etf_pkg::IN_WIDTH-1:0]       julia_c_im,
    output logic [etf_pkg::MAX_ITER_WIDTH-1:0]        max_iterations
);

    import etf_pkg::*;

    logic                          mode_reg;
    logic signed [IN_WIDTH-1:0]    c_re_reg;
    logic signed [IN_WIDTH-1:0]    c_im_reg;
    logic [MAX_ITER_WIDTH-1:0]     max_iter_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            c_re_reg     <= '0;
            c_im_reg     <= '0;
            max_iter_reg <= MAX_ITER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FRACTAL_MODE:   mode_reg     <= cfg_data[0];
                CFG_JULIA_C_RE:     c_re_reg     <= IN_WIDTH'(cfg_data);
                CFG_JULIA_C_IM:     c_im_reg     <= IN_WIDTH'(cfg_data);
                CFG_MAX_ITERATIONS: max_iter_reg <= cfg_data[MAX_ITER_WIDTH-1:0];
                default:            ;
            endcase
        end
    end

    assign fractal_mode   = mode_reg;
    assign julia_c_re     = c_re_reg;
    assign julia_c_im     = c_im_reg;
    assign max_iterations = max_iter_reg;

endmodule

`default_nettype wire

// ===== design/etf_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// etf_mul
// two-stage signed fixed-point multiplier: four half-width partial products,
// then sum and arithmetic shift right (truncation toward minus infinity)
// ----------------------------------------------------------------------------
module etf_mul #(
    parameter int W     = 38,
    parameter int SHIFT = 28
) (
    input  wire logic                clk,
    input  wire logic signed [W-1:0] a,
    input  wire logic signed [W-1:0] b,
    output logic signed [W-1:0]      p
);

    localparam int LO = W / 2;
    localparam int HI = W - LO;

    logic [LO-1:0]          a_lo;
    logic [LO-1:0]          b_lo;
    logic signed [HI-1:0]   a_hi;
    logic signed [HI-1:0]   b_hi;

    logic [2*LO-1:0]        p_ll_next;
    logic signed [W:0]      p_lh_next;
    logic signed [W:0]      p_hl_next;
    logic signed [2*HI-1:0] p_hh_next;

    logic [2*LO-1:0]        p_ll_reg;
    logic signed [W:0]      p_lh_reg;
    logic signed [W:0]      p_hl_reg;
    logic signed [2*HI-1:0] p_hh_reg;

    logic signed [2*W-1:0]  full;
    logic signed [2*W-1:0]  shifted;
    logic signed [W-1:0]    p_next;
    logic signed [W-1:0]    p_reg;

    always_comb
    begin
        a_lo      = a[LO-1:0];
        b_lo      = b[LO-1:0];
        a_hi      = a[W-1:LO];
        b_hi      = b[W-1:LO];
        p_ll_next = a_lo * b_lo;
        p_lh_next = $signed({1'b0, a_lo}) * b_hi;
        p_hl_next = a_hi * $signed({1'b0, b_lo});
        p_hh_next = a_hi * b_hi;
    end

    always_comb
    begin
        full    = $signed({{(2*HI){1'b0}}, p_ll_reg})
                + ((2*W)'(p_lh_reg) <<< LO)
                + ((2*W)'(p_hl_reg) <<< LO)
                + ((2*W)'(p_hh_reg) <<< (2*LO));
        shifted = full >>> SHIFT;
        p_next  = shifted[W-1:0];
    end

    always_ff @(posedge clk)
    begin
        p_ll_reg <= p_ll_next;
        p_lh_reg <= p_lh_next;
        p_hl_reg <= p_hl_next;
        p_hh_reg <= p_hh_next;
        p_reg    <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== design/etf_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// etf_datapath
// z and c registers, three multipliers, escape and limit tests,
// iteration counter and result register
// ----------------------------------------------------------------------------
module etf_datapath #(
    parameter int FRAC_BITS   = etf_pkg::FRAC_BITS_DEFAULT,
    parameter int COUNT_WIDTH = etf_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire etf_pkg::etf_cmd_t                    cmd,
    output etf_pkg::etf_status_t                      status,
    input  wire logic signed [etf_pkg::IN_WIDTH-1:0]  point_re,
    input  wire logic signed [etf_pkg::IN_WIDTH-1:0]  point_im,
    input  wire logic                                 fractal_mode,
    input  wire logic signed [etf_pkg::IN_WIDTH-1:0]  julia_c_re,
    input  wire logic signed [etf_pkg::IN_WIDTH-1:0]  julia_c_im,
    input  wire logic [etf_pkg::MAX_ITER_WIDTH-1:0]   max_iterations,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [etf_pkg::OUT_WIDTH-1:0]             iteration_count
);

    import etf_pkg::*;

    localparam int W        = INT_BITS + FRAC_BITS;
    localparam int SHIFT_UP = (FRAC_BITS >= IN_FRAC) ? FRAC_BITS - IN_FRAC : 0;
    localparam int SHIFT_DN = (FRAC_BITS < IN_FRAC) ? IN_FRAC - FRAC_BITS : 0;
    localparam int LW       = (COUNT_WIDTH > MAX_ITER_WIDTH) ? COUNT_WIDTH
                                                             : MAX_ITER_WIDTH;

    localparam logic signed [W:0]  FOUR = (W+1)'(4) << FRAC_BITS;
    localparam logic [LW-1:0]      CAP  = LW'({COUNT_WIDTH{1'b1}});

    function automatic logic signed [W-1:0] to_internal(input logic signed [IN_WIDTH-1:0] x);
        logic signed [W-1:0] y;
        if (FRAC_BITS >= IN_FRAC)
            y = W'(x) <<< SHIFT_UP;
        else
            y = W'(x >>> SHIFT_DN);
        return y;
    endfunction

    logic signed [W-1:0]      zr_reg, zr_next;
    logic signed [W-1:0]      zi_reg, zi_next;
    logic signed [W-1:0]      cr_reg, cr_next;
    logic signed [W-1:0]      ci_reg, ci_next;
    logic [COUNT_WIDTH-1:0]   count_reg, count_next;
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_WIDTH-1:0]     out_data_reg, out_data_next;

    logic signed [W-1:0]      zr2;
    logic signed [W-1:0]      zi2;
    logic signed [W-1:0]      cross_term;
    logic signed [W:0]        mag2;
    logic [LW-1:0]            limit;
    logic signed [W-1:0]      pr;
    logic signed [W-1:0]      pi;

    etf_mul #(.W(W), .SHIFT(FRAC_BITS)) u_sq_re (
        .clk (clk),
        .a   (zr_reg),
        .b   (zr_reg),
        .p   (zr2)
    );

    etf_mul #(.W(W), .SHIFT(FRAC_BITS)) u_sq_im (
        .clk (clk),
        .a   (zi_reg),
        .b   (zi_reg),
        .p   (zi2)
    );

    // doubled cross term: one bit less of shift
    etf_mul #(.W(W), .SHIFT(FRAC_BITS - 1)) u_cross (
        .clk (clk),
        .a   (zr_reg),
        .b   (zi_reg),
        .p   (cross_term)
    );

    always_comb
    begin
        pr    = to_internal(point_re);
        pi    = to_internal(point_im);
        mag2  = (W+1)'(zr2) + (W+1)'(zi2);
        limit = (LW'(max_iterations) < CAP) ? LW'(max_iterations) : CAP;

        status.escaped  = mag2 > FOUR;
        status.at_limit = LW'(count_reg) >= limit;
        status.out_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            count_next = '0;
            if (fractal_mode)
            begin
                zr_next = pr;
                zi_next = pi;
                cr_next = to_internal(julia_c_re);
                ci_next = to_internal(julia_c_im);
            end
            else
            begin
                zr_next = '0;
                zi_next = '0;
                cr_next = pr;
                ci_next = pi;
            end
        end
        else if (cmd.step)
        begin
            zr_next    = zr2 - zi2 + cr_reg;
            zi_next    = cross_term + ci_reg;
            count_next = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = OUT_WIDTH'(count_reg);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        zr_reg       <= zr_next;
        zi_reg       <= zi_next;
        cr_reg       <= cr_next;
        ci_reg       <= ci_next;
        count_reg    <= count_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid       = out_valid_reg;
    assign iteration_count = out_data_reg;

endmodule

`default_nettype wire

// ===== design/etf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// etf_ctrl
// iteration sequencer: load, multiply, sum, test, and result handoff
// ----------------------------------------------------------------------------
module etf_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output etf_pkg::etf_cmd_t          cmd,
    input  wire etf_pkg::etf_status_t  status
);

    import etf_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_TEST = 3'd3;
    localparam logic [2:0] ST_HOLD = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       finished;

    assign finished = status.escaped || status.at_limit;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
                state_next = ST_SUM;
            ST_SUM:
                state_next = ST_TEST;
            ST_TEST:
            begin
                if (!finished)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_MUL;
                end
                else if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== design/escape_time_fractal_iterator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator_core
// escape-time iteration count of one complex point, mandelbrot or julia mode
//
//   channel  direction  signals
//   in       sink       in_valid, in_ready, point_re, point_im
//   out      source     out_valid, out_ready, iteration_count
//   cfg      sink       cfg_valid, cfg_ready, cfg_index, cfg_data
//
// a point is taken only in idle, once the last result has gone to the
// output register; each iteration steps through partial products, sum
// and shift, then test and update, paced by the split multipliers' registers
// reset clears the sequencer, the result valid and the config registers to defaults
// a waiting result sits in the output register; the next point is taken
// meanwhile and its finish stalls only while that result is still held
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator_core #(
    parameter int FRAC_BITS   = etf_pkg::FRAC_BITS_DEFAULT,
    parameter int COUNT_WIDTH = etf_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [etf_pkg::IN_WIDTH-1:0]  point_re,
    input  wire logic signed [etf_pkg::IN_WIDTH-1:0]  point_im,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [etf_pkg::OUT_WIDTH-1:0]             iteration_count,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [etf_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [etf_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

    import etf_pkg::*;

    etf_cmd_t                    cmd;
    etf_status_t                 status;
    logic                        fractal_mode;
    logic signed [IN_WIDTH-1:0]  julia_c_re;
    logic signed [IN_WIDTH-1:0]  julia_c_im;
    logic [MAX_ITER_WIDTH-1:0]   max_iterations;

    etf_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fractal_mode   (fractal_mode),
        .julia_c_re     (julia_c_re),
        .julia_c_im     (julia_c_im),
        .max_iterations (max_iterations)
    );

    etf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    etf_datapath #(
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .point_re        (point_re),
        .point_im        (point_im),
        .fractal_mode    (fractal_mode),
        .julia_c_re      (julia_c_re),
        .julia_c_im      (julia_c_im),
        .max_iterations  (max_iterations),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .iteration_count (iteration_count)
    );

endmodule

`default_nettype wire
